### sv/prime_moduli_residue_splitter_macros.svh
// assertion macros used by the checker file
`ifndef PRIME_MODULI_RESIDUE_SPLITTER_MACROS_SVH
`define PRIME_MODULI_RESIDUE_SPLITTER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PMRS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmrs check failed");

// next-cycle implication, disabled while reset is low
`define PMRS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmrs check failed");

`endif

### sv/pmrs_pkg.sv
package pmrs_pkg;

    // field widths
    localparam int VAL_W   = 31;
    localparam int PRIME_W = 9;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int TBL_DEPTH = 64;

    // one value bit per divider stage
    localparam int NUM_STAGES = VAL_W;

    localparam logic [CNT_W-1:0] COUNT_RESET = 7'd16;

    // one residue job moving down the divider pipeline
    typedef struct packed {
        logic               vld;
        logic [VAL_W-1:0]   val;
        logic [PRIME_W-1:0] rem;
        logic [PRIME_W-1:0] prime;
        logic [IDX_W-1:0]   idx;
        logic               last;
    } t_stage;

    // first 64 primes in ascending order
    function automatic logic [PRIME_W-1:0] prime_at(input logic [IDX_W-1:0] idx);
        logic [PRIME_W-1:0] p;
        case (idx)
            6'd0:  p = 9'd2;    6'd1:  p = 9'd3;    6'd2:  p = 9'd5;    6'd3:  p = 9'd7;
            6'd4:  p = 9'd11;   6'd5:  p = 9'd13;   6'd6:  p = 9'd17;   6'd7:  p = 9'd19;
            6'd8:  p = 9'd23;   6'd9:  p = 9'd29;   6'd10: p = 9'd31;   6'd11: p = 9'd37;
            6'd12: p = 9'd41;   6'd13: p = 9'd43;   6'd14: p = 9'd47;   6'd15: p = 9'd53;
            6'd16: p = 9'd59;   6'd17: p = 9'd61;   6'd18: p = 9'd67;   6'd19: p = 9'd71;
            6'd20: p = 9'd73;   6'd21: p = 9'd79;   6'd22: p = 9'd83;   6'd23: p = 9'd89;
            6'd24: p = 9'd97;   6'd25: p = 9'd101;  6'd26: p = 9'd103;  6'd27: p = 9'd107;
            6'd28: p = 9'd109;  6'd29: p = 9'd113;  6'd30: p = 9'd127;  6'd31: p = 9'd131;
            6'd32: p = 9'd137;  6'd33: p = 9'd139;  6'd34: p = 9'd149;  6'd35: p = 9'd151;
            6'd36: p = 9'd157;  6'd37: p = 9'd163;  6'd38: p = 9'd167;  6'd39: p = 9'd173;
            6'd40: p = 9'd179;  6'd41: p = 9'd181;  6'd42: p = 9'd191;  6'd43: p = 9'd193;
            6'd44: p = 9'd197;  6'd45: p = 9'd199;  6'd46: p = 9'd211;  6'd47: p = 9'd223;
            6'd48: p = 9'd227;  6'd49: p = 9'd229;  6'd50: p = 9'd233;  6'd51: p = 9'd239;
            6'd52: p = 9'd241;  6'd53: p = 9'd251;  6'd54: p = 9'd257;  6'd55: p = 9'd263;
            6'd56: p = 9'd269;  6'd57: p = 9'd271;  6'd58: p = 9'd277;  6'd59: p = 9'd281;
            6'd60: p = 9'd283;  6'd61: p = 9'd293;  6'd62: p = 9'd307;  6'd63: p = 9'd311;
            default: p = 9'd2;
        endcase
        return p;
    endfunction

    // one restoring step: bring in the next value bit, subtract the prime if it fits
    function automatic t_stage div_step(input t_stage s);
        t_stage o;
        logic [PRIME_W:0] trial;
        o     = s;
        trial = {s.rem, s.val[VAL_W-1]};
        if (trial >= {1'b0, s.prime}) begin
            trial = trial - {1'b0, s.prime};
        end
        o.rem = trial[PRIME_W-1:0];
        o.val = {s.val[VAL_W-2:0], 1'b0};
        return o;
    endfunction

endpackage

### sv/pmrs_rom.sv
module pmrs_rom
    import pmrs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [IDX_W-1:0]   i_addr,
    output logic [PRIME_W-1:0] o_data
);

    logic [PRIME_W-1:0] r_data;

    // prime table, registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= prime_at(i_addr);
        end
    end

    assign o_data = r_data;

endmodule

### sv/pmrs_div.sv
module pmrs_div
    import pmrs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_stage i_job,
    output t_stage o_job
);

    t_stage r_stg [NUM_STAGES];

    // bit-serial remainder pipeline, stalls as a whole
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_STAGES; s++) begin
                r_stg[s] <= '0;
            end
        end else if (i_en) begin
            r_stg[0] <= div_step(i_job);
            for (int s = 1; s < NUM_STAGES; s++) begin
                r_stg[s] <= div_step(r_stg[s-1]);
            end
        end
    end

    assign o_job = r_stg[NUM_STAGES-1];

endmodule

### sv/prime_moduli_residue_splitter.sv
// Splits a 31-bit value into its residues modulo the first K primes (K from the
// prime_count register, 0 read as 1, capped at MAX_PRIMES) and returns one result
// item per prime in ascending order, last_of_run marking the final one. The sequencer
// reads one prime per cycle from the prime table while the output is not stalled; the
// next item is taken in the cycle the last prime of the current one is issued. Each
// residue then passes the table read and tag register and a 31-stage bit-serial
// remainder pipeline, and results follow one per cycle while the output is taken.
// A stall at the output holds the whole pipeline.
module prime_moduli_residue_splitter
    import pmrs_pkg::*;
#(
    parameter int MAX_PRIMES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [VAL_W-1:0]   i_secret_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [PRIME_W-1:0] o_prime_modulus,
    output logic [IDX_W-1:0]   o_prime_index,
    output logic [PRIME_W-1:0] o_residue,
    output logic               o_last_of_run
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PRIMES);

    logic [CNT_W-1:0]   r_count;
    logic               r_busy;
    logic [VAL_W-1:0]   r_val;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_last_idx;
    t_stage             r_tag;
    logic               en;
    logic               accept;
    logic               issue_last;
    logic [CNT_W-1:0]   eff_last;
    logic [PRIME_W-1:0] rom_prime;
    t_stage             job_in;
    t_stage             job_out;

    // prime count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    // last prime index of a run, count clamped to 1..MAX_PRIMES
    always_comb begin
        if (r_count == '0) begin
            eff_last = '0;
        end else if (r_count > MAX_CNT) begin
            eff_last = MAX_CNT - 1'b1;
        end else begin
            eff_last = r_count - 1'b1;
        end
    end

    assign en         = !job_out.vld || i_out_ready;
    assign issue_last = r_busy && (r_idx == r_last_idx);
    assign o_in_ready = !r_busy || (en && issue_last);
    assign accept     = i_in_valid && o_in_ready;

    // sequencer walks the prime indexes of one item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy     <= 1'b1;
            r_val      <= i_secret_value;
            r_idx      <= '0;
            r_last_idx <= eff_last[IDX_W-1:0];
        end else if (en && r_busy) begin
            if (issue_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // tag stage lines up with the table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (en) begin
            r_tag.vld   <= r_busy;
            r_tag.val   <= r_val;
            r_tag.rem   <= '0;
            r_tag.prime <= '0;
            r_tag.idx   <= r_idx;
            r_tag.last  <= issue_last;
        end
    end

    pmrs_rom u_rom (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_addr (r_idx),
        .o_data (rom_prime)
    );

    // merge the prime into the job entering the divider
    always_comb begin
        job_in       = r_tag;
        job_in.prime = rom_prime;
        job_in.rem   = '0;
    end

    pmrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_job   (job_in),
        .o_job   (job_out)
    );

    // result item comes straight from the last divider stage
    assign o_out_valid     = job_out.vld;
    assign o_prime_modulus = job_out.prime;
    assign o_prime_index   = job_out.idx;
    assign o_residue       = job_out.rem;
    assign o_last_of_run   = job_out.last;

endmodule

### sv/pmrs_chk.sv
`include "prime_moduli_residue_splitter_macros.svh"

module pmrs_chk
    import pmrs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic [CNT_W-1:0]   i_cfg_wdata,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [VAL_W-1:0]   i_secret_value,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [PRIME_W-1:0] o_prime_modulus,
    input logic [IDX_W-1:0]   o_prime_index,
    input logic [PRIME_W-1:0] o_residue,
    input logic               o_last_of_run
);

    // a stalled result item stays offered
    `PMRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // a residue is always below its prime
    `PMRS_ASSERT_NOW(a_res_range, i_clk, i_rst_n, o_out_valid, o_residue < o_prime_modulus)

    // every run opens with the prime 2
    `PMRS_ASSERT_NOW(a_first_prime, i_clk, i_rst_n, o_out_valid && (o_prime_index == '0),
        o_prime_modulus == 9'd2)

    // the top table index always closes a run
    `PMRS_ASSERT_NOW(a_top_last, i_clk, i_rst_n, o_out_valid && (o_prime_index == '1),
        o_last_of_run)

endmodule

bind prime_moduli_residue_splitter pmrs_chk u_pmrs_chk (.*);
